// File: rtl/three_channel_line_detector_unit_macros.svh
// Assertion macros shared by the line detector checker.
`ifndef THREE_CHANNEL_LINE_DETECTOR_UNIT_MACROS_SVH
`define THREE_CHANNEL_LINE_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcld assertion failed");

// next-cycle implication, disabled during reset
`define TCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcld assertion failed");

`endif

// File: rtl/tcld_pkg.sv
// Types and constants of the three-channel line detector.
package tcld_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;
    localparam int LEVEL_W    = 8;

    localparam logic [CH_W-1:0]     LAST_CH   = 2'd2;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 8'd255;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd1015;
    localparam logic [LEVEL_W-1:0]  STABLE_RESET    = 8'd7;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_STABLE    = 1'b1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_DEB,
        ST_DONE
    } t_state;

endpackage

// File: rtl/tcld_win.sv
// Window sample memory shared by the three channels.
module tcld_win #(
    parameter int DEPTH  = 9,
    parameter int ADDR_W = 4
) (
    input  logic                          i_clk,
    input  logic [ADDR_W-1:0]             i_addr,
    input  logic                          i_re,
    input  logic                          i_we,
    input  logic [tcld_pkg::SAMPLE_W-1:0] i_wdata,
    output logic [tcld_pkg::SAMPLE_W-1:0] o_rdata
);
    import tcld_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tcld_div.sv
// Restoring divider, one quotient bit per cycle.
module tcld_div #(
    parameter int SUM_W = 12,
    parameter int DIV_W = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic [SUM_W-1:0] o_quotient,
    output logic             o_done
);
    import tcld_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [DIV_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, i_divisor};
    assign w_diff  = w_shift - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits DIV_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: rtl/three_channel_line_detector_unit.sv
// Three-channel line detector: moving averages, threshold and debounce counter.
//
// Each input beat carries one 10-bit sample per channel (left, middle, right).
// The channels are handled one after another through a single window memory
// and a single restoring divider that yields one quotient bit per cycle. Each
// channel takes a memory read, a sum update and a divider run over SUM_W bits,
// SUM_W being the running-sum width ($clog2(WINDOW_LENGTH*1023+1)); after the
// last channel the debounce counter is updated and the result register loaded
// once the output is free. The next beat can be taken in the cycle after that
// load at the earliest. s_axis_tready is high only while the block is idle.
// The result sits in an output register, so the next beat is taken while a
// finished result still waits on m_axis_tready. The
// window memory needs no clearing after reset: slots are filled in order and a
// slot read before the window has filled counts as zero. Registers
// (i_cfg_index): 0 detect threshold, 1 stable count; write only while idle.
module three_channel_line_detector_unit #(
    parameter int WINDOW_LENGTH = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample_left [9:0], sample_middle [19:10], sample_right [29:20], zero fill
    input  logic [tcld_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // average_left [9:0], average_middle [19:10], average_right [29:20],
    // line_now [30], line_stable [31], debounce_level [39:32]
    output logic [tcld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [tcld_pkg::SAMPLE_W-1:0]   i_cfg_data
);
    import tcld_pkg::*;

    localparam int SUM_W  = $clog2(WINDOW_LENGTH * SAMPLE_MAX + 1);
    localparam int DIV_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int DEPTH  = NUM_CH * WINDOW_LENGTH;
    localparam int ADDR_W = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [CH_W-1:0]     r_ch;
    logic [SAMPLE_W-1:0] r_samp [NUM_CH];
    logic [SUM_W-1:0]    r_sum  [NUM_CH];
    logic [SAMPLE_W-1:0] r_avg  [NUM_CH];
    logic                r_now;
    logic [LEVEL_W-1:0]  r_level;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_full;
    logic [DIV_W-1:0]    r_n;
    logic [SAMPLE_W-1:0] r_thr;
    logic [LEVEL_W-1:0]  r_req;
    logic                r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic                c_accept;
    logic                c_mem_re;
    logic                c_sum;
    logic                c_div_take;
    logic                c_deb;
    logic                c_load_out;

    logic [ADDR_W-1:0]   w_addr;
    logic [SAMPLE_W-1:0] w_rdata;
    logic [SAMPLE_W-1:0] w_old;
    logic [SUM_W-1:0]    w_new_sum;
    logic [SUM_W-1:0]    w_quo;
    logic [SAMPLE_W-1:0] w_avg;
    logic                w_div_done;
    logic                w_out_free;

    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_addr     = ADDR_W'(r_ch * WINDOW_LENGTH + r_slot);
    // slot not yet written before the window fills
    assign w_old      = r_full ? w_rdata : '0;
    assign w_new_sum  = r_sum[r_ch] - SUM_W'(w_old) + SUM_W'(r_samp[r_ch]);
    assign w_avg      = w_quo[SAMPLE_W-1:0];

    tcld_win #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_win (
        .i_clk   (i_clk),
        .i_addr  (w_addr),
        .i_re    (c_mem_re),
        .i_we    (c_sum),
        .i_wdata (r_samp[r_ch]),
        .o_rdata (w_rdata)
    );

    tcld_div #(
        .SUM_W (SUM_W),
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_sum),
        .i_dividend (w_new_sum),
        .i_divisor  (r_n),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_READ;
            ST_READ: n_state = ST_SUM;
            ST_SUM:  n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = (r_ch == LAST_CH) ? ST_DEB : ST_READ;
                end
            end
            ST_DEB:  n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        c_mem_re      = 1'b0;
        c_sum         = 1'b0;
        c_div_take    = 1'b0;
        c_deb         = 1'b0;
        c_load_out    = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_READ: c_mem_re      = 1'b1;
            ST_SUM:  c_sum         = 1'b1;
            ST_DIV:  c_div_take    = w_div_done;
            ST_DEB:  c_deb         = 1'b1;
            ST_DONE: c_load_out    = w_out_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign c_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ch     <= '0;
            r_slot   <= '0;
            r_full   <= 1'b0;
            r_level  <= '0;
            r_now    <= 1'b0;
            r_thr    <= THRESHOLD_RESET;
            r_req    <= STABLE_RESET;
            r_ovalid <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: r_thr <= i_cfg_data;
                    CFG_STABLE:    r_req <= i_cfg_data[LEVEL_W-1:0];
                    default:       r_thr <= r_thr;
                endcase
            end

            if (c_accept) begin
                r_ch  <= '0;
                r_now <= 1'b0;
            end

            if (c_sum) begin
                r_sum[r_ch] <= w_new_sum;
            end

            if (c_div_take) begin
                if (w_avg > r_thr) begin
                    r_now <= 1'b1;
                end
                if (r_ch != LAST_CH) begin
                    r_ch <= r_ch + CH_W'(1);
                end
            end

            if (c_deb) begin
                if (r_slot == SLOT_W'(WINDOW_LENGTH - 1)) begin
                    r_slot <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
                if (r_now) begin
                    if (r_level != LEVEL_MAX) r_level <= r_level + LEVEL_W'(1);
                end else begin
                    if (r_level != '0) r_level <= r_level - LEVEL_W'(1);
                end
            end

            if (c_load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_samp[0] <= s_axis_tdata[SAMPLE_W-1:0];
            r_samp[1] <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            r_samp[2] <= s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
            r_n       <= r_full ? DIV_W'(WINDOW_LENGTH) : DIV_W'(r_slot) + DIV_W'(1);
        end
        if (c_div_take) begin
            r_avg[r_ch] <= w_avg;
        end
        if (c_load_out) begin
            r_odata <= {r_level, (r_level >= r_req), r_now, r_avg[2], r_avg[1], r_avg[0]};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

// File: rtl/tcld_checker.sv
// Port-level checker for the line detector, bound to the top level.
`include "three_channel_line_detector_unit_macros.svh"

module tcld_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tcld_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tcld_pkg::*;

    logic               w_in_beat;
    logic               w_out_wait;
    logic [LEVEL_W-1:0] w_level;
    logic               w_line_now;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_wait = m_axis_tvalid && !m_axis_tready;
    assign w_level    = m_axis_tdata[39:32];
    assign w_line_now = m_axis_tdata[30];

    // one beat at a time: busy right after an accepted beat
    `TCLD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_beat, !s_axis_tready)

    // counter at zero after the update means nothing was seen this beat
    `TCLD_ASSERT_NOW(a_zero_level_no_line, i_clk, i_rst_n, m_axis_tvalid && (w_level == '0), !w_line_now)

    // counter at the top after the update means a line was seen this beat
    `TCLD_ASSERT_NOW(a_max_level_line, i_clk, i_rst_n, m_axis_tvalid && (w_level == LEVEL_MAX), w_line_now)

    `TCLD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind three_channel_line_detector_unit tcld_checker u_tcld_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the three-channel line detector unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcld_pkg::*;

    localparam int WIN_LEN   = 3;
    localparam int SUM_W     = $clog2(WIN_LEN * SAMPLE_MAX + 1);
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [IN_DATA_W-3*SAMPLE_W-1:0] fill;
        logic [SAMPLE_W-1:0]             right;
        logic [SAMPLE_W-1:0]             middle;
        logic [SAMPLE_W-1:0]             left;
    } t_sensor_beat;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic                stable;
        logic                line_now;
        logic [SAMPLE_W-1:0] avg_right;
        logic [SAMPLE_W-1:0] avg_middle;
        logic [SAMPLE_W-1:0] avg_left;
    } t_line_result;

    typedef struct {
        logic [SAMPLE_W-1:0] left, middle, right;
        bit                  typed;
        logic [SAMPLE_W-1:0] avg_left, avg_middle, avg_right;
        bit                  line_now, stable;
        logic [LEVEL_W-1:0]  level;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = CFG_THRESHOLD;
    logic [SAMPLE_W-1:0]   i_cfg_data = '0;

    three_channel_line_detector_unit #(
        .WINDOW_LENGTH(WIN_LEN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // detector state as the block should hold it
    logic [SAMPLE_W-1:0] window_samples [NUM_CH][WIN_LEN];
    logic [SUM_W-1:0]    running_sum [NUM_CH];
    int                  next_slot;
    bit                  window_filled;
    logic [LEVEL_W-1:0]  debounce_level;
    logic [SAMPLE_W-1:0] threshold_reg;
    logic [LEVEL_W-1:0]  stable_req_reg;

    t_line_result awaited_results [$];
    int           errors = 0;
    int           burst_left = 0;
    int           hold_asked = 0;
    int           holds_done = 0;

    // line segment generator state
    int       seg_remaining = 0;
    bit [2:0] seg_mask;
    int       seg_kind;

    t_directed_row directed_rows [24] = '{
        // cleared window, averages over a partly filled window
        '{10'd0,    10'd0,    10'd0,    1'b1, 10'd0,    10'd0,    10'd0,    1'b0, 1'b0, 8'd0},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd511,  10'd511,  10'd511,  1'b0, 1'b0, 8'd0},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd682,  10'd682,  10'd682,  1'b0, 1'b0, 8'd0},
        // full scale, counter climbs to the stable count
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0, 8'd1},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0, 8'd2},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0, 8'd3},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0, 8'd4},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0, 8'd5},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0, 8'd6},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1, 8'd7},
        // one channel at a time
        '{10'd0,    10'd1023, 10'd0,    1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd0,    10'd1023, 10'd0,    1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd0,    10'd1023, 10'd0,    1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd0,    10'd0,    10'd1023, 1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd0,    10'd0,    10'd1023, 1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd0,    10'd0,    10'd1023, 1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        // just above and exactly at the threshold, then mixed and zero samples
        '{10'd1016, 10'd0,    10'd0,    1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd1016, 10'd0,    10'd0,    1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd1016, 10'd0,    10'd0,    1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd1015, 10'd1015, 10'd1015, 1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd1015, 10'd1015, 10'd1015, 1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd341,  10'd682,  10'd341,  1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd682,  10'd341,  10'd682,  1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0},
        '{10'd0,    10'd0,    10'd0,    1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 8'd0}
    };

    function automatic void clear_detection_model();
        for (int c = 0; c < NUM_CH; c++) begin
            running_sum[c] = '0;
            for (int k = 0; k < WIN_LEN; k++)
                window_samples[c][k] = '0;
        end
        next_slot      = 0;
        window_filled  = 1'b0;
        debounce_level = '0;
        threshold_reg  = THRESHOLD_RESET;
        stable_req_reg = STABLE_RESET;
    endfunction

    function automatic t_line_result predict_detection(input t_sensor_beat beat);
        t_line_result        res;
        logic [SAMPLE_W-1:0] smp [NUM_CH];
        logic [SAMPLE_W-1:0] avg [NUM_CH];
        int                  divisor;
        bit                  present;
        smp[0]  = beat.left;
        smp[1]  = beat.middle;
        smp[2]  = beat.right;
        divisor = window_filled ? WIN_LEN : next_slot + 1;
        present = 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
            running_sum[c] = running_sum[c] - window_samples[c][next_slot] + smp[c];
            window_samples[c][next_slot] = smp[c];
            avg[c] = SAMPLE_W'(running_sum[c] / divisor);
            if (avg[c] > threshold_reg)
                present = 1'b1;
        end
        next_slot++;
        if (next_slot >= WIN_LEN) begin
            next_slot     = 0;
            window_filled = 1'b1;
        end
        // saturating up/down debounce
        if (present) begin
            if (debounce_level != LEVEL_MAX)
                debounce_level++;
        end else if (debounce_level != '0) begin
            debounce_level--;
        end
        res.avg_left   = avg[0];
        res.avg_middle = avg[1];
        res.avg_right  = avg[2];
        res.line_now   = present;
        res.stable     = (debounce_level >= stable_req_reg);
        res.level      = debounce_level;
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] line_sample();
        int v;
        case (seg_kind)
            0: v = $urandom_range(SAMPLE_MAX, 900);
            1: v = int'(threshold_reg) + int'($urandom_range(8, 0)) - 4;
            2: v = SAMPLE_MAX;
            default: v = $urandom_range(SAMPLE_MAX, 0);
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    // mostly line segments crossing a random subset of sensors, some noise
    function automatic t_sensor_beat draw_sensor_beat();
        t_sensor_beat        beat;
        logic [SAMPLE_W-1:0] smp [NUM_CH];
        if (seg_remaining == 0) begin
            seg_remaining = $urandom_range(24, 1);
            seg_mask      = 3'($urandom_range(7, 0));
            seg_kind      = $urandom_range(3, 0);
        end
        seg_remaining--;
        for (int c = 0; c < NUM_CH; c++) begin
            if ($urandom_range(9, 0) == 0)
                smp[c] = SAMPLE_W'($urandom);
            else if (seg_mask[c])
                smp[c] = line_sample();
            else
                smp[c] = SAMPLE_W'($urandom_range(150, 0));
        end
        beat.fill   = '0;
        beat.left   = smp[0];
        beat.middle = smp[1];
        beat.right  = smp[2];
        return beat;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(70, 1);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // called just after a rising edge; returns at the edge that takes the beat
    task automatic send_sensor_beat(input t_sensor_beat beat, input bit typed,
                                    input t_line_result typed_want);
        t_line_result predicted;
        pace_sender();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(negedge i_clk); while (!s_axis_tready);
        predicted = predict_detection(beat);
        awaited_results.push_back(typed ? typed_want : predicted);
        @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [SAMPLE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            threshold_reg = val;
        else
            stable_req_reg = val[LEVEL_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            // receiver backs off for a while; the input side must stall
            if (i == count / 3)
                hold_asked++;
            send_sensor_beat(draw_sensor_beat(), 1'b0, '0);
        end
        wait_for_drain();
    endtask

    initial begin : stimulus
        t_sensor_beat beat;
        t_line_result want;
        clear_detection_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        foreach (directed_rows[k]) begin
            beat.fill       = '0;
            beat.left       = directed_rows[k].left;
            beat.middle     = directed_rows[k].middle;
            beat.right      = directed_rows[k].right;
            want.avg_left   = directed_rows[k].avg_left;
            want.avg_middle = directed_rows[k].avg_middle;
            want.avg_right  = directed_rows[k].avg_right;
            want.line_now   = directed_rows[k].line_now;
            want.stable     = directed_rows[k].stable;
            want.level      = directed_rows[k].level;
            send_sensor_beat(beat, directed_rows[k].typed, want);
        end
        wait_for_drain();

        // everything is a line, counter saturates high; stable count truncates to zero
        write_register(CFG_THRESHOLD, 10'd0);
        write_register(CFG_STABLE, 10'h300);
        run_random_phase(300);

        // nothing is a line, counter drains to zero; stable count truncates to 255
        write_register(CFG_THRESHOLD, 10'h3FF);
        write_register(CFG_STABLE, 10'h3FF);
        run_random_phase(300);

        repeat (2) begin
            write_register(CFG_THRESHOLD, SAMPLE_W'($urandom_range(1000, 50)));
            write_register(CFG_STABLE, SAMPLE_W'($urandom));
            run_random_phase(175);
        end

        write_register(CFG_THRESHOLD, THRESHOLD_RESET);
        write_register(CFG_STABLE, SAMPLE_W'(STABLE_RESET));
        run_random_phase(300);

        repeat (60) @(posedge i_clk);
        if (awaited_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (errors == 0) begin
            $display("three_channel_line_detector_unit test passed");
        end else begin
            $display("three_channel_line_detector_unit test failed");
        end
        $finish;
    end

    initial begin : result_sink
        int run;
        @(posedge i_clk);
        forever begin
            if (holds_done < hold_asked) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else begin
                case ($urandom_range(3, 0))
                    0: begin
                        m_axis_tready <= 1'b0;
                        run = $urandom_range(30, 1);
                    end
                    1: begin
                        m_axis_tready <= 1'b1;
                        run = $urandom_range(30, 1);
                    end
                    2: begin
                        m_axis_tready <= 1'b1;
                        run = $urandom_range(400, 100);
                    end
                    default: begin
                        m_axis_tready <= 1'b0;
                        run = $urandom_range(6, 1);
                    end
                endcase
                repeat (run) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_line_result got;
        t_line_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result %h with none outstanding", m_axis_tdata));
            end else begin
                want = awaited_results.pop_front();
                if (got.avg_left !== want.avg_left)
                    flag_mismatch($sformatf("average_left %0d, want %0d",
                                            got.avg_left, want.avg_left));
                if (got.avg_middle !== want.avg_middle)
                    flag_mismatch($sformatf("average_middle %0d, want %0d",
                                            got.avg_middle, want.avg_middle));
                if (got.avg_right !== want.avg_right)
                    flag_mismatch($sformatf("average_right %0d, want %0d",
                                            got.avg_right, want.avg_right));
                if (got.line_now !== want.line_now)
                    flag_mismatch($sformatf("line_now %b, want %b",
                                            got.line_now, want.line_now));
                if (got.stable !== want.stable)
                    flag_mismatch($sformatf("line_stable %b, want %b",
                                            got.stable, want.stable));
                if (got.level !== want.level)
                    flag_mismatch($sformatf("debounce_level %0d, want %0d",
                                            got.level, want.level));
            end
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("three_channel_line_detector_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/tcld_pkg.sv
rtl/tcld_win.sv
rtl/tcld_div.sv
rtl/three_channel_line_detector_unit.sv
rtl/tcld_checker.sv
tb/sv/tb_top.sv
